@@ sv/ple_pkg.sv @@
// Shared types, codes and constants of the positional list engine.
`default_nettype none

package ple_pkg;

	// Sizes
	localparam int CAPACITY_DEF = 64;
	localparam int VAL_W        = 32;
	localparam int POS_W        = 8;
	localparam int OUT_W        = 7;
	localparam int GRP_W        = 8;   // match bits scanned per cycle

	// Request modes
	localparam logic [1:0] MODE_INS  = 2'd0;
	localparam logic [1:0] MODE_DEL  = 2'd1;
	localparam logic [1:0] MODE_SRCH = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// Request beat
	typedef struct packed {
		logic [1:0]              mode;
		logic signed [VAL_W-1:0] item_value;
		logic [POS_W-1:0]        position;
	} req_t;

	// Result beat
	typedef struct packed {
		logic [1:0]       status;
		logic [OUT_W-1:0] found_position;
		logic [OUT_W-1:0] entry_count;
	} rsp_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] pidx;   // zero-based target index
		logic [VAL_W-1:0] val;    // value to load or search key
		logic [POS_W-1:0] cnt;    // current entry count
	} cell_cmd_t;

	// Scanner status back to the controller
	typedef struct packed {
		logic             done;
		logic             found;
		logic [POS_W-1:0] where;  // one-based position of first match
	} scan_res_t;

endpackage

`default_nettype wire

@@ sv/ple_stream_if.sv @@
// Valid/ready stream interface carrying one payload per beat.
`default_nettype none

interface ple_stream_if #(parameter type payload_t = logic [7:0]);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

@@ sv/ple_cell.sv @@
// One list cell: holds one entry, shifts from its neighbors, compares to the key.
`default_nettype none

module ple_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  ple_pkg::cell_cmd_t            cmd,
	input  logic [ple_pkg::VAL_W-1:0]     left,
	input  logic [ple_pkg::VAL_W-1:0]     right,
	output logic [ple_pkg::VAL_W-1:0]     value,
	output logic                          match
);

	localparam logic [ple_pkg::POS_W-1:0] IDX_P = ple_pkg::POS_W'(IDX);

	logic [ple_pkg::VAL_W-1:0] value_q;

	// Insert: load at target, take left neighbor above it.
	// Delete: take right neighbor from target upward.
	always_ff @(posedge clk) begin
		if (cmd.ins && (IDX_P >= cmd.pidx)) begin
			value_q <= (IDX_P == cmd.pidx) ? cmd.val : left;
		end else if (cmd.del && (IDX_P >= cmd.pidx)) begin
			value_q <= right;
		end
	end

	assign value = value_q;

	// Only occupied cells can match
	assign match = (value_q == cmd.val) && (IDX_P < cmd.cnt);

endmodule

`default_nettype wire

@@ sv/ple_scan.sv @@
// First-match scanner: walks the registered match vector one group per cycle.
`default_nettype none

module ple_scan #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CAPACITY-1:0] match,
	output ple_pkg::scan_res_t  res
);

	localparam int NGRP = (CAPACITY + ple_pkg::GRP_W - 1) / ple_pkg::GRP_W;
	localparam int VW   = NGRP * ple_pkg::GRP_W;

	logic [VW-1:0]                vec_q;
	logic [ple_pkg::POS_W-1:0]    base_q;
	logic                         busy_q;
	logic [ple_pkg::GRP_W-1:0]    low;
	logic [2:0]                   enc;
	logic                         hit;
	logic                         done;

	assign low = vec_q[ple_pkg::GRP_W-1:0];
	assign hit = |low;

	// Lowest set bit of the current group
	always_comb begin
		enc = 3'd0;
		for (int i = ple_pkg::GRP_W - 1; i >= 0; i--) begin
			if (low[i]) begin
				enc = 3'(i);
			end
		end
	end

	// Done on a hit, or when nothing is left to scan
	assign done = busy_q && (hit || !(|vec_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// Vector shift and group base
	always_ff @(posedge clk) begin
		if (start) begin
			vec_q  <= VW'(match);
			base_q <= '0;
		end else if (busy_q && !done) begin
			vec_q  <= vec_q >> ple_pkg::GRP_W;
			base_q <= base_q + ple_pkg::POS_W'(ple_pkg::GRP_W);
		end
	end

	assign res.done  = done;
	assign res.found = hit;
	assign res.where = base_q + ple_pkg::POS_W'(enc) + ple_pkg::POS_W'(1);

endmodule

`default_nettype wire

@@ sv/positional_list_engine.sv @@
// Positional list engine: chain of entry cells, first-match scanner, control.
// Insert, delete and rejected requests: result is registered in the output register,
//   or parked while the output stalls; one request per cycle while results drain.
// Search: the cell compares are captured into the scanner as the request is taken,
//   then the scanner covers 8 cells per cycle; no new request is taken meanwhile.
// Reset clears the entry count and all control state; entry contents are not
//   cleared (no clearing pass), they are only read below the count.
`default_nettype none

module positional_list_engine #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ple_stream_if.sink    req,
	ple_stream_if.source  rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_nxt;
	ple_pkg::req_t             rq;
	ple_pkg::rsp_t             res_d;
	ple_pkg::rsp_t             res_q;
	ple_pkg::rsp_t             out_q;
	ple_pkg::rsp_t             new_res;
	logic                      out_valid_q;
	logic                      out_free;
	logic                      accept;
	logic                      do_ins;
	logic                      do_del;
	logic                      is_srch;
	logic                      ins_bad;
	logic                      del_bad;
	logic                      full;
	logic [8:0]                cnt9;
	logic [8:0]                pos9;
	logic                      have_res;
	ple_pkg::cell_cmd_t        cmd;
	ple_pkg::scan_res_t        scan;
	logic [CAPACITY-1:0]       match;
	logic [ple_pkg::VAL_W-1:0] vals [CAPACITY];

	assign rq       = req.payload;
	assign req.ready = (state_q == S_IDLE);
	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	// Position checks
	assign cnt9    = 9'(count_q);
	assign pos9    = {1'b0, rq.position};
	assign ins_bad = (rq.position == '0) || (pos9 > (cnt9 + 9'd1));
	assign del_bad = (rq.position == '0) || (pos9 > cnt9);
	assign full    = (count_q == CW'(CAPACITY));

	// Decode request and build its immediate result
	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		is_srch = 1'b0;
		res_d.status = ple_pkg::ST_BAD_POS;
		case (rq.mode)
			ple_pkg::MODE_INS: begin
				if (ins_bad) begin
					res_d.status = ple_pkg::ST_BAD_POS;
				end else if (full) begin
					res_d.status = ple_pkg::ST_FULL;
				end else begin
					res_d.status = ple_pkg::ST_OK;
					do_ins = 1'b1;
				end
			end
			ple_pkg::MODE_DEL: begin
				if (del_bad) begin
					res_d.status = ple_pkg::ST_BAD_POS;
				end else begin
					res_d.status = ple_pkg::ST_OK;
					do_del = 1'b1;
				end
			end
			ple_pkg::MODE_SRCH: begin
				is_srch = 1'b1;
			end
			default: begin
				res_d.status = ple_pkg::ST_BAD_POS;
			end
		endcase
		if (do_ins) begin
			count_nxt = count_q + CW'(1);
		end else if (do_del) begin
			count_nxt = count_q - CW'(1);
		end else begin
			count_nxt = count_q;
		end
		res_d.found_position = '0;
		res_d.entry_count    = ple_pkg::OUT_W'(count_nxt);
	end

	// Broadcast command to the chain
	assign cmd.ins  = accept && do_ins;
	assign cmd.del  = accept && do_del;
	assign cmd.pidx = rq.position - ple_pkg::POS_W'(1);
	assign cmd.val  = rq.item_value;
	assign cmd.cnt  = ple_pkg::POS_W'(count_q);

	// Cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ple_pkg::VAL_W-1:0] left_v;
		logic [ple_pkg::VAL_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = rq.item_value;
		end else begin : g_mid_l
			assign left_v = vals[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = vals[i];
		end else begin : g_mid_r
			assign right_v = vals[i+1];
		end
		ple_cell #(.IDX(i)) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.left  (left_v),
			.right (right_v),
			.value (vals[i]),
			.match (match[i])
		);
	end

	ple_scan #(.CAPACITY(CAPACITY)) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && is_srch),
		.match  (match),
		.res    (scan)
	);

	// Result produced this cycle, if any
	always_comb begin
		have_res = 1'b0;
		new_res  = res_d;
		if (state_q == S_IDLE) begin
			have_res = accept && !is_srch;
		end else if (state_q == S_SCAN) begin
			have_res               = scan.done;
			new_res.status         = scan.found ? ple_pkg::ST_OK : ple_pkg::ST_MISSING;
			new_res.found_position = scan.found ? ple_pkg::OUT_W'(scan.where) : '0;
			new_res.entry_count    = ple_pkg::OUT_W'(count_q);
		end
	end

	// Control and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && is_srch) begin
						state_q <= S_SCAN;
					end else if (have_res && !out_free) begin
						state_q <= S_HOLD;
					end
				end
				S_SCAN: begin
					if (have_res) begin
						state_q <= out_free ? S_IDLE : S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((have_res || (state_q == S_HOLD)) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register and parked result
	always_ff @(posedge clk) begin
		if (state_q == S_HOLD) begin
			if (out_free) begin
				out_q <= res_q;
			end
		end else if (have_res) begin
			if (out_free) begin
				out_q <= new_res;
			end else begin
				res_q <= new_res;
			end
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

`default_nettype wire

@@ sv/ple_checker.sv @@
// Port-level checker for the positional list engine, with its bind.
`default_nettype none

module ple_checker #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input ple_pkg::req_t req_payload,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ple_pkg::rsp_t rsp_payload
);

	// Stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result beat changed while stalled");

	// A search blocks new requests while it scans
	a_srch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_payload.mode == ple_pkg::MODE_SRCH) |=> !req_ready)
		else $error("request taken during a search");

	// Full status only with a full list
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.status == ple_pkg::ST_FULL)
		|-> rsp_payload.entry_count == ple_pkg::OUT_W'(CAPACITY))
		else $error("full status with list not full");

	// Not found carries no position
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.status == ple_pkg::ST_MISSING)
		|-> rsp_payload.found_position == '0)
		else $error("not found with nonzero position");

	// A position is reported only with ok status
	a_pos_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.found_position != '0)
		|-> rsp_payload.status == ple_pkg::ST_OK)
		else $error("position reported without ok status");

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_payload (req.payload),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the positional list engine: list predictor, drivers, checker.
`default_nettype none

module testbench;
	import ple_pkg::*;

	localparam int          CAP            = CAPACITY_DEF;
	localparam logic [1:0]  MODE_UNUSED    = 2'd3;
	localparam int          HOLD_CYCLES    = 80;
	localparam int          WATCHDOG_LIMIT = 1000;
	localparam int          SETTLE_CYCLES  = 16;
	localparam int          RANDOM_ITEMS   = 400;
	localparam int          DIRECTED_ITEMS = 24;
	localparam int          PRINT_LIMIT    = 40;

	// Predicts each result from a private copy of the list and checks results in order
	class list_scoreboard;
		logic [VAL_W-1:0] slots [CAP];
		int               held;
		rsp_t             due_q [$];
		int               mismatches;

		function new();
			held       = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		// Apply one accepted request to the list and queue the result it must give
		function void note_request(input req_t r);
			int          i;
			int          pos;
			logic [1:0]  st;
			int          where;
			rsp_t        exp_rsp;
			pos   = r.position;
			st    = ST_OK;
			where = 0;
			case (r.mode)
				MODE_INS: begin
					if (pos == 0 || pos > held + 1)
						st = ST_BAD_POS;
					else if (held >= CAP)
						st = ST_FULL;
					else begin
						for (i = held; i >= pos; i--)
							slots[i] = slots[i-1];
						slots[pos-1] = r.item_value;
						held++;
					end
				end
				MODE_DEL: begin
					if (pos == 0 || pos > held)
						st = ST_BAD_POS;
					else begin
						for (i = pos - 1; i + 1 < held; i++)
							slots[i] = slots[i+1];
						held--;
					end
				end
				MODE_SRCH: begin
					st = ST_MISSING;
					for (i = 0; i < held; i++) begin
						if (where == 0 && slots[i] == r.item_value) begin
							where = i + 1;
							st    = ST_OK;
						end
					end
				end
				default: st = ST_BAD_POS;
			endcase
			exp_rsp.status         = st;
			exp_rsp.found_position = where[OUT_W-1:0];
			exp_rsp.entry_count    = held[OUT_W-1:0];
			due_q.push_back(exp_rsp);
		endfunction

		task report(input string what, input int got, input int want);
			if (mismatches < PRINT_LIMIT)
				$display("MISMATCH %s: got %0d expected %0d", what, got, want);
			mismatches++;
		endtask

		task check_result(input rsp_t got);
			rsp_t want;
			if (due_q.size() == 0) begin
				report("result with nothing outstanding", got, 0);
				return;
			end
			want = due_q.pop_front();
			if (got.status !== want.status)
				report("status", got.status, want.status);
			if (got.found_position !== want.found_position)
				report("found_position", got.found_position, want.found_position);
			if (got.entry_count !== want.entry_count)
				report("entry_count", got.entry_count, want.entry_count);
		endtask
	endclass

	logic clk;
	logic arst_n;

	ple_stream_if #(.payload_t(req_t)) req_if ();
	ple_stream_if #(.payload_t(rsp_t)) rsp_if ();

	positional_list_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	list_scoreboard sb = new();

	bit hold_off_req;
	bit bursty;
	int burst_left;
	int items_sent;
	int idle_cycles = 0;

	// Clock and reset
	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Result checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready)
				sb.check_result(rsp_if.payload);
			if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
				idle_cycles <= 0;
			else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", idle_cycles);
				$display("positional_list_engine verification failed");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Result receiver: stall patterns in segments, plus one long hold-off on request
	initial begin : receiver
		int seg;
		int style;
		int tick;
		bit held_done;
		rsp_if.ready = 1'b0;
		tick      = 0;
		held_done = 1'b0;
		forever begin
			seg   = $urandom_range(50, 10);
			style = $urandom_range(2);
			repeat (seg) begin
				@(posedge clk);
				tick++;
				if (hold_off_req && !held_done) begin
					held_done = 1'b1;
					rsp_if.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (style)
					0:       rsp_if.ready <= 1'b1;
					1:       rsp_if.ready <= 1'($urandom_range(1));
					default: rsp_if.ready <= (tick % 4 != 0);
				endcase
			end
		end
	end

	function automatic req_t make_req(input logic [1:0] mode, input logic [VAL_W-1:0] val,
			input int pos);
		req_t r;
		r.mode       = mode;
		r.item_value = val;
		r.position   = pos[POS_W-1:0];
		return r;
	endfunction

	// Mostly wide random values, sometimes a few small ones so duplicates occur
	function automatic logic [VAL_W-1:0] any_value();
		if ($urandom_range(3) == 0)
			return int'($urandom_range(6)) - 3;
		return $urandom;
	endfunction

	function automatic logic [VAL_W-1:0] present_value();
		return sb.slots[$urandom_range(sb.held - 1)];
	endfunction

	// One random request, biased toward growing or shrinking the list
	function automatic req_t pick_request(input bit growing);
		int roll;
		int op;
		roll = $urandom_range(99);
		if (roll < 8)
			return make_req(2'($urandom_range(3)), $urandom, $urandom_range(255));
		op = $urandom_range(99);
		if (op < (growing ? 60 : 15))
			return make_req(MODE_INS, any_value(), $urandom_range(sb.held + 1, 1));
		if (op < 75) begin
			if (sb.held == 0)
				return make_req(MODE_DEL, any_value(), 1);
			return make_req(MODE_DEL, any_value(), $urandom_range(sb.held, 1));
		end
		if (sb.held > 0 && $urandom_range(9) < 7)
			return make_req(MODE_SRCH, present_value(), $urandom_range(255));
		return make_req(MODE_SRCH, any_value(), $urandom_range(255));
	endfunction

	// Offer one request until it is taken, then maybe leave a gap
	task automatic offer(input req_t r);
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		sb.note_request(r);
		items_sent++;
		if (bursty) begin
			if (burst_left == 0) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(8, 1)) @(posedge clk);
				burst_left = $urandom_range(16, 1);
			end else
				burst_left--;
		end
	endtask

	task automatic pause_until_drained();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic random_round(input bit growing, input int n);
		repeat (n) offer(pick_request(growing));
	endtask

	// Fill the list to capacity with random content, then poke at the full list
	task automatic fill_to_full();
		while (sb.held < CAP) begin
			if ($urandom_range(4) == 0 && sb.held > 0)
				offer(make_req(MODE_SRCH, present_value(), $urandom_range(255)));
			else
				offer(make_req(MODE_INS, any_value(), $urandom_range(sb.held + 1, 1)));
		end
		repeat (3) offer(make_req(MODE_INS, any_value(), $urandom_range(CAP + 1, 1)));
		offer(make_req(MODE_INS, any_value(), CAP + 2));
		offer(make_req(MODE_SRCH, sb.slots[CAP-1], 0));
		offer(make_req(MODE_SRCH, present_value(), 0));
	endtask

	// Empty the list with random deletes and searches
	task automatic empty_out();
		while (sb.held > 0) begin
			if ($urandom_range(3) == 0)
				offer(make_req(MODE_SRCH, present_value(), $urandom_range(255)));
			else
				offer(make_req(MODE_DEL, any_value(), $urandom_range(sb.held, 1)));
		end
		offer(make_req(MODE_DEL, any_value(), 1));
	endtask

	// Request sender: directed cases, then random rounds
	initial begin : sender
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		hold_off_req   = 1'b0;
		bursty         = 1'b0;
		burst_left     = 0;
		items_sent     = 0;
		@(posedge clk iff arst_n);

		// Empty list, bad positions, value extremes, first match among duplicates
		offer(make_req(MODE_DEL, 32'h0, 1));
		offer(make_req(MODE_SRCH, 32'h0, 0));
		offer(make_req(MODE_INS, 32'h5, 0));
		offer(make_req(MODE_INS, 32'h5, 2));
		offer(make_req(MODE_INS, 32'h7FFF_FFFF, 1));
		offer(make_req(MODE_INS, 32'h8000_0000, 1));
		offer(make_req(MODE_INS, 32'h0, 3));
		offer(make_req(MODE_INS, 32'hFFFF_FFFF, 2));
		offer(make_req(MODE_INS, 32'h1, 255));
		offer(make_req(MODE_INS, 32'h1, 6));
		offer(make_req(MODE_INS, 32'hFFFF_FFFF, 5));
		offer(make_req(MODE_SRCH, 32'hFFFF_FFFF, 0));
		offer(make_req(MODE_SRCH, 32'h7FFF_FFFF, 255));
		offer(make_req(MODE_SRCH, 32'h8000_0000, 0));
		offer(make_req(MODE_SRCH, 32'd12345, 0));
		offer(make_req(MODE_UNUSED, 32'hFFFF_FFFF, 255));
		offer(make_req(MODE_DEL, 32'h0, 0));
		offer(make_req(MODE_DEL, 32'h0, 6));
		offer(make_req(MODE_DEL, 32'h0, 255));
		offer(make_req(MODE_DEL, 32'h0, 1));
		offer(make_req(MODE_DEL, 32'h0, 4));
		offer(make_req(MODE_DEL, 32'h0, 2));
		offer(make_req(MODE_SRCH, 32'h7FFF_FFFF, 0));
		offer(make_req(MODE_SRCH, 32'h0, 0));
		pause_until_drained();

		// Random traffic; one long output hold-off while requests keep coming
		bursty = 1'b1;
		random_round(1'b1, 40);
		bursty       = 1'b0;
		hold_off_req = 1'b1;
		random_round(1'b1, 30);
		bursty = 1'b1;
		fill_to_full();
		pause_until_drained();
		empty_out();
		while (items_sent < RANDOM_ITEMS + DIRECTED_ITEMS) begin
			bursty = ($urandom_range(3) != 0);
			random_round(1'($urandom_range(1)), $urandom_range(60, 20));
		end

		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("positional_list_engine verification clean");
		else
			$display("positional_list_engine verification failed");
		$finish;
	end

endmodule

`default_nettype wire
